FILE: rtl/sfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared widths, type codes and result codes of the serial frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

  // Field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 2;

  typedef logic [BYTE_W-1:0]   byte_t;
  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [VALUE_W-1:0]  value_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [POS_W-1:0]    pos_t;

  // Framing bytes on the link
  localparam byte_t SYNC_BYTE    = 8'hAA;
  localparam byte_t TYPE_STRING  = 8'h80;
  localparam byte_t TYPE_UINT32  = 8'h81;
  localparam byte_t TYPE_FLOAT   = 8'h82;
  localparam byte_t TYPE_COMMAND = 8'h83;

  // Frame kind codes on the result
  localparam kind_t KIND_STRING  = 2'd0;
  localparam kind_t KIND_UINT32  = 2'd1;
  localparam kind_t KIND_FLOAT   = 2'd2;
  localparam kind_t KIND_COMMAND = 2'd3;

  // End status codes on the result
  localparam status_t END_COMPLETE = 2'd0;
  localparam status_t END_ILLEGAL  = 2'd1;
  localparam status_t END_START    = 2'd2;

  // Byte positions of the last byte of a word or command
  localparam pos_t WORD_LAST_POS = 2'd3;
  localparam pos_t CMD_LAST_POS  = 2'd1;

endpackage
`default_nettype wire

FILE: rtl/sfd_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_in_if
// Valid/ready channel carrying one received link byte per beat.
// ----------------------------------------------------------------------------
interface sfd_in_if
  import sfd_pkg::*;
  ;
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

FILE: rtl/sfd_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_out_if
// Valid/ready channel carrying one deframed result per beat.
// ----------------------------------------------------------------------------
interface sfd_out_if
  import sfd_pkg::*;
  ;
  logic    valid;
  logic    ready;
  kind_t   frame_kind;
  value_t  value;
  logic    has_char;
  logic    last;
  status_t end_status;

  modport source (output valid, output frame_kind, output value, output has_char,
                  output last, output end_status, input ready);
  modport sink   (input valid, input frame_kind, input value, input has_char,
                  input last, input end_status, output ready);
endinterface
`default_nettype wire

FILE: rtl/serial_frame_deframer_unit.sv
`default_nettype none
// Output: a result is registered and appears on the output register in the cycle
//   after the byte that completes it is accepted.
// Throughput: one byte per cycle; the result register takes a new beat in the
//   same cycle the waiting one is taken, so ready only drops while it is full.
// Reset: synchronous, active high; parser returns to sync-byte hunting and the
//   result register is emptied.
// ----------------------------------------------------------------------------
// serial_frame_deframer_unit
// Hunts for the sync byte, decodes the type byte and emits string characters,
// 32-bit words or 16-bit command ids as frames arrive byte by byte.
// ----------------------------------------------------------------------------
module serial_frame_deframer_unit
  import sfd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  sfd_in_if.sink     rx,
  sfd_out_if.source  frame
);

  // Parser phases, one-hot
  typedef enum logic [5:0] {
    PH_HUNT  = 6'b000001,
    PH_TYPE  = 6'b000010,
    PH_LEN   = 6'b000100,
    PH_CHARS = 6'b001000,
    PH_WORD  = 6'b010000,
    PH_CMD   = 6'b100000
  } phase_t;

  phase_t phase, phase_next;
  kind_t  kind_held, kind_held_next;
  byte_t  bytes_left, bytes_left_next;
  value_t word_build, word_build_next;
  pos_t   byte_pos, byte_pos_next;

  logic    emit;
  kind_t   res_kind;
  value_t  res_value;
  logic    res_has_char;
  logic    res_last;
  status_t res_status;

  logic   accept;
  value_t word_merged;
  byte_t  b;

  // Result register empties or is taken this cycle
  assign rx.ready = !frame.valid || frame.ready;
  assign accept   = rx.valid && rx.ready;
  assign b        = rx.rx_byte;

  // Current byte placed at its little-endian lane
  always_comb begin
    unique case (byte_pos)
      2'd0:    word_merged = word_build | {24'd0, b};
      2'd1:    word_merged = word_build | {16'd0, b, 8'd0};
      2'd2:    word_merged = word_build | {8'd0, b, 16'd0};
      default: word_merged = word_build | {b, 24'd0};
    endcase
  end

  // Per-byte parser step
  always_comb begin
    phase_next      = phase;
    kind_held_next  = kind_held;
    bytes_left_next = bytes_left;
    word_build_next = word_build;
    byte_pos_next   = byte_pos;
    emit            = 1'b0;
    res_kind        = KIND_STRING;
    res_value       = '0;
    res_has_char    = 1'b0;
    res_last        = 1'b1;
    res_status      = END_COMPLETE;

    unique case (phase)
      PH_TYPE: begin
        word_build_next = '0;
        byte_pos_next   = '0;
        priority if (b == TYPE_STRING) begin
          kind_held_next = KIND_STRING;
          phase_next     = PH_LEN;
        end else if (b == TYPE_UINT32 || b == TYPE_FLOAT) begin
          kind_held_next = b[KIND_W-1:0];
          phase_next     = PH_WORD;
        end else if (b == TYPE_COMMAND) begin
          kind_held_next = KIND_COMMAND;
          phase_next     = PH_CMD;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_LEN: begin
        bytes_left_next = b;
        if (b == '0) begin
          // empty string: one terminating result
          phase_next = PH_HUNT;
          emit       = 1'b1;
        end else begin
          phase_next = PH_CHARS;
        end
      end
      PH_CHARS: begin
        emit = 1'b1;
        priority if (!b[BYTE_W-1]) begin
          bytes_left_next = bytes_left - 8'd1;
          res_value       = {24'd0, b};
          res_has_char    = 1'b1;
          res_last        = (bytes_left == 8'd1);
          if (bytes_left == 8'd1) phase_next = PH_HUNT;
        end else if (b == SYNC_BYTE) begin
          // sync byte cuts the string and resyncs to a type byte
          bytes_left_next = '0;
          res_status      = END_START;
          phase_next      = PH_TYPE;
        end else begin
          bytes_left_next = '0;
          res_status      = END_ILLEGAL;
          phase_next      = PH_HUNT;
        end
      end
      PH_WORD, PH_CMD: begin
        if ((phase == PH_WORD && byte_pos == WORD_LAST_POS) ||
            (phase == PH_CMD && byte_pos == CMD_LAST_POS)) begin
          emit            = 1'b1;
          res_kind        = kind_held;
          res_value       = (phase == PH_CMD) ? {16'd0, word_merged[15:0]} : word_merged;
          phase_next      = PH_HUNT;
          byte_pos_next   = '0;
          word_build_next = '0;
        end else begin
          word_build_next = word_merged;
          byte_pos_next   = byte_pos + 2'd1;
        end
      end
      default: begin
        phase_next = (b == SYNC_BYTE) ? PH_TYPE : PH_HUNT;
      end
    endcase
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      kind_held  <= KIND_STRING;
      bytes_left <= '0;
      word_build <= '0;
      byte_pos   <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      kind_held  <= kind_held_next;
      bytes_left <= bytes_left_next;
      word_build <= word_build_next;
      byte_pos   <= byte_pos_next;
    end
  end

  // Result register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      frame.valid <= 1'b0;
    end else if (accept && emit) begin
      frame.valid <= 1'b1;
    end else if (frame.ready) begin
      frame.valid <= 1'b0;
    end
  end

  // Result register: payload
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      frame.frame_kind <= res_kind;
      frame.value      <= res_value;
      frame.has_char   <= res_has_char;
      frame.last       <= res_last;
      frame.end_status <= res_status;
    end
  end

endmodule
`default_nettype wire

FILE: tb/sfd_frame_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_frame_monitor
// Watches the byte and result channels of the deframer. It runs its own
// deframing of every accepted byte, queues the results that byte should
// produce, and compares every accepted result beat field by field.
// ----------------------------------------------------------------------------
module sfd_frame_monitor
  import sfd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  sfd_in_if           rx,
  sfd_out_if          frame,
  output int unsigned errors,
  output int unsigned results_due
);

  typedef enum logic [2:0] {
    LINK_HUNT,
    LINK_TYPE,
    LINK_LEN,
    LINK_CHARS,
    LINK_WORD,
    LINK_CMD
  } link_phase_e;

  typedef struct packed {
    kind_t   kind;
    value_t  value;
    logic    has_char;
    logic    last;
    status_t status;
  } frame_result_t;

  // Characters must stay below this; anything at or above ends the string
  localparam byte_t CHAR_LIMIT = 8'h80;

  // Local copy of the parser state
  link_phase_e link_phase;
  kind_t       kind_held;
  byte_t       bytes_left;
  value_t      word_build;
  pos_t        byte_pos;

  frame_result_t frames_pending[$];

  function automatic frame_result_t make_result(kind_t k, value_t v, logic c, logic l,
                                                status_t s);
    frame_result_t r;
    r.kind     = k;
    r.value    = v;
    r.has_char = c;
    r.last     = l;
    r.status   = s;
    return r;
  endfunction

  // Append one expected result at the tail
  function automatic void queue_result(input frame_result_t r);
    frames_pending.insert(frames_pending.size(), r);
  endfunction

  task automatic flag_error(input string what, input logic [31:0] got,
                            input logic [31:0] want);
    $display("%0t ns: %s got 0x%0h, want 0x%0h", $time, what, got, want);
    errors++;
  endtask

  // Advance the parser by one received byte and queue what it emits
  task automatic deframe_byte(input byte_t b);
    case (link_phase)
      LINK_TYPE: begin
        word_build = '0;
        byte_pos   = '0;
        if (b == TYPE_STRING) begin
          kind_held  = KIND_STRING;
          link_phase = LINK_LEN;
        end else if (b == TYPE_UINT32) begin
          kind_held  = KIND_UINT32;
          link_phase = LINK_WORD;
        end else if (b == TYPE_FLOAT) begin
          kind_held  = KIND_FLOAT;
          link_phase = LINK_WORD;
        end else if (b == TYPE_COMMAND) begin
          kind_held  = KIND_COMMAND;
          link_phase = LINK_CMD;
        end else begin
          // unknown type, the sync byte too: drop the frame
          link_phase = LINK_HUNT;
        end
      end
      LINK_LEN: begin
        bytes_left = b;
        if (b == '0) begin
          // empty string still closes with one beat
          link_phase = LINK_HUNT;
          queue_result(make_result(KIND_STRING, '0, 1'b0, 1'b1, END_COMPLETE));
        end else begin
          link_phase = LINK_CHARS;
        end
      end
      LINK_CHARS: begin
        if (b < CHAR_LIMIT) begin
          bytes_left = bytes_left - 1'b1;
          queue_result(make_result(KIND_STRING, value_t'(b), 1'b1,
                                   bytes_left == '0, END_COMPLETE));
          if (bytes_left == '0)
            link_phase = LINK_HUNT;
        end else begin
          bytes_left = '0;
          if (b == SYNC_BYTE) begin
            // sync byte inside a string: next byte is a type byte
            link_phase = LINK_TYPE;
            queue_result(make_result(KIND_STRING, '0, 1'b0, 1'b1, END_START));
          end else begin
            link_phase = LINK_HUNT;
            queue_result(make_result(KIND_STRING, '0, 1'b0, 1'b1, END_ILLEGAL));
          end
        end
      end
      LINK_WORD, LINK_CMD: begin
        word_build = word_build | (value_t'(b) << (8 * byte_pos));
        if ((link_phase == LINK_WORD && byte_pos == WORD_LAST_POS) ||
            (link_phase == LINK_CMD && byte_pos == CMD_LAST_POS)) begin
          queue_result(make_result(kind_held,
            (link_phase == LINK_CMD) ? {16'h0000, word_build[15:0]} : word_build,
            1'b0, 1'b1, END_COMPLETE));
          link_phase = LINK_HUNT;
          byte_pos   = '0;
          word_build = '0;
        end else begin
          byte_pos = byte_pos + 1'b1;
        end
      end
      default: begin
        link_phase = (b == SYNC_BYTE) ? LINK_TYPE : LINK_HUNT;
      end
    endcase
  endtask

  // Result beats are compared before the byte of the same edge is parsed:
  // a byte never yields a result in the cycle it is taken
  always @(posedge clk) begin
    frame_result_t due;
    if (rst) begin
      link_phase = LINK_HUNT;
      kind_held  = '0;
      bytes_left = '0;
      word_build = '0;
      byte_pos   = '0;
      frames_pending.delete();
      results_due <= 0;
    end else begin
      if (frame.valid && frame.ready) begin
        if (frames_pending.size() == 0) begin
          flag_error("result beat with nothing due, value", frame.value, '0);
        end else begin
          due = frames_pending.pop_front();
          if (frame.frame_kind !== due.kind)
            flag_error("frame_kind", frame.frame_kind, due.kind);
          if (frame.value !== due.value)
            flag_error("value", frame.value, due.value);
          if (frame.has_char !== due.has_char)
            flag_error("has_char", frame.has_char, due.has_char);
          if (frame.last !== due.last)
            flag_error("last", frame.last, due.last);
          if (frame.end_status !== due.status)
            flag_error("end_status", frame.end_status, due.status);
        end
      end
      if (rx.valid && rx.ready)
        deframe_byte(rx.rx_byte);
      results_due <= frames_pending.size();
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives received bytes into the serial frame deframer: a short run of
// hand-built frames, then random frames with some noise and cut frames, with
// random gaps and stalls on both channels, one long output hold-off and two
// full drains. The frame monitor predicts and checks; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb;
  import sfd_pkg::*;

  logic clk = 1'b0;
  logic rst;

  sfd_in_if  rx_ch ();
  sfd_out_if frame_ch ();

  int unsigned mismatches;
  int unsigned results_due;

  bit          src_gaps;
  bit          sink_gaps;
  bit          hold_request;
  bit          resync;
  int unsigned framed_bytes;

  // Hand-built frames: unknown type (sync byte as type), empty string,
  // string with extreme characters cut by an illegal byte, all-ones word,
  // command id, string cut by the sync byte and resynced into a float
  byte_t opening_bytes[$] = '{
    SYNC_BYTE, SYNC_BYTE,
    SYNC_BYTE, TYPE_STRING, 8'h00,
    SYNC_BYTE, TYPE_STRING, 8'h03, 8'h00, 8'h7F, 8'hFF,
    SYNC_BYTE, TYPE_UINT32, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    SYNC_BYTE, TYPE_COMMAND, 8'h34, 8'h12,
    SYNC_BYTE, TYPE_STRING, 8'h01, SYNC_BYTE, TYPE_FLOAT, 8'h00, 8'h00, 8'h00, 8'h80
  };

  always #2 clk = ~clk;

  serial_frame_deframer_unit dut (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx_ch),
    .frame (frame_ch)
  );

  sfd_frame_monitor monitor (
    .clk         (clk),
    .rst         (rst),
    .rx          (rx_ch),
    .frame       (frame_ch),
    .errors      (mismatches),
    .results_due (results_due)
  );

  // Offer one byte, with random idle cycles first, and wait for its beat
  task automatic send_byte(input byte_t b, input bit counted = 1'b1);
    while (src_gaps && $urandom_range(0, 99) < 32) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    if (counted)
      framed_bytes++;
  endtask

  // Stop offering until every queued result has come out
  task automatic drain_results();
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  // One random frame; mostly well formed, some cut short or garbled
  task automatic send_random_frame();
    int unsigned pick;
    int unsigned len;
    int unsigned roll;
    bit          cut;
    byte_t       b;
    if (!resync)
      send_byte(SYNC_BYTE);
    resync = 1'b0;
    pick   = $urandom_range(0, 99);
    if (pick < 40) begin
      send_byte(TYPE_STRING);
      len = ($urandom_range(0, 39) == 0) ? $urandom_range(100, 255) : $urandom_range(0, 10);
      send_byte(byte_t'(len));
      cut = 1'b0;
      for (int i = 0; i < len && !cut; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          send_byte(SYNC_BYTE);
          resync = 1'b1;
          cut    = 1'b1;
        end else if (roll < 6) begin
          b = byte_t'($urandom_range(128, 255));
          if (b == SYNC_BYTE)
            b = TYPE_STRING;
          send_byte(b);
          cut = 1'b1;
        end else begin
          send_byte(byte_t'($urandom_range(0, 127)));
        end
      end
    end else if (pick < 75) begin
      send_byte(pick < 60 ? TYPE_UINT32 : TYPE_FLOAT);
      repeat (4) send_byte(byte_t'($urandom_range(0, 255)));
    end else if (pick < 92) begin
      send_byte(TYPE_COMMAND);
      repeat (2) send_byte(byte_t'($urandom_range(0, 255)));
    end else if (pick < 95) begin
      // unknown type byte
      b = byte_t'($urandom_range(0, 255));
      if (b >= TYPE_STRING && b <= TYPE_COMMAND)
        b = SYNC_BYTE;
      send_byte(b);
    end else if (pick < 97) begin
      // word frame broken off; the following sync byte lands in the word
      send_byte(TYPE_UINT32);
      repeat ($urandom_range(1, 3)) send_byte(byte_t'($urandom_range(0, 255)));
    end else begin
      // line noise while hunting
      repeat ($urandom_range(1, 4)) send_byte(byte_t'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // Result side: random stalls, or one long hold-off on request
  initial begin
    frame_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        frame_ch.ready <= 1'b0;
        repeat (80) @(posedge clk);
      end else begin
        frame_ch.ready <= !(sink_gaps && $urandom_range(0, 99) < 32);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= '0;
    rst           <= 1'b1;
    src_gaps     = 1'b1;
    sink_gaps    = 1'b1;
    hold_request = 1'b0;
    resync       = 1'b0;
    framed_bytes = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (opening_bytes[i]) send_byte(opening_bytes[i]);

    while (framed_bytes < 200) send_random_frame();

    // output held off while bytes keep coming
    hold_request = 1'b1;
    while (framed_bytes < 260) send_random_frame();

    drain_results();

    // stretch with no gaps or stalls on either side
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    while (framed_bytes < 400) send_random_frame();

    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    while (framed_bytes < 520) send_random_frame();

    drain_results();
    repeat (8) @(posedge clk);

    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
